// ----- rtl/b5fa_pkg.sv -----
// Shared types and constants for the Big5 text stream to font address block.
package b5fa_pkg;

  // Payload of one incoming text item.
  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } text_item_t;

  // Payload of one glyph item.
  typedef struct packed {
    logic        glyph_kind;
    logic [15:0] serial_number;
    logic [2:0]  font_select;
    logic [18:0] byte_offset;
    logic [7:0]  glyph_code;
    logic        final_glyph;
  } glyph_item_t;

  // Decoder result for one text item: up to two glyphs and the next lead state.
  typedef struct packed {
    logic [1:0]  count;
    glyph_item_t first;
    glyph_item_t second;
    logic        held_next;
  } decode_t;

  localparam logic GLYPH_ASCII = 1'b0;
  localparam logic GLYPH_BIG5  = 1'b1;

  localparam logic [2:0] FONT_ASCII    = 3'd0;
  localparam logic [2:0] FONT_SUPPLEM  = 3'd1;
  localparam logic [2:0] FONT_SPECIAL  = 3'd2;
  localparam logic [2:0] FONT_STANDARD = 3'd3;
  localparam logic [2:0] FONT_NONE     = 3'd4;

  localparam logic [15:0] SERIAL_ROW   = 16'h009d;
  localparam logic [15:0] BASE_SUPPLEM = 16'h8001;
  localparam logic [15:0] BASE_SPECIAL = 16'h8400;
  localparam logic [15:0] BASE_STANDARD = 16'h8800;
  localparam logic [15:0] BASE_EXTRA   = 16'h805f;
  localparam logic [15:0] BASE_HIGH    = 16'h9d19;
  localparam logic [15:0] LAST_SUPPLEM = 16'h816d;
  localparam logic [15:0] LAST_SPECIAL = 16'h8597;
  localparam logic [15:0] LAST_STANDARD = 16'hbb25;
  localparam logic [7:0]  TRAIL_SKIP   = 8'h3f;

  localparam logic [18:0] GLYPH_BYTES = 19'd30;
  localparam logic [18:0] ASCII_BYTES = 19'd15;

endpackage

// ----- rtl/b5fa_decode.sv -----
// Pairs a held lead byte with the next byte and builds the resulting glyph items.
module b5fa_decode (
  input  logic                   lead_held,
  input  logic [7:0]             lead_value,
  input  b5fa_pkg::text_item_t   item,
  output b5fa_pkg::decode_t      result
);
  import b5fa_pkg::*;

  logic [7:0]  hi;
  logic [7:0]  lo;
  logic        supp_pair;
  logic        lead_ok;
  logic        trail_ok;
  logic        pair_ok;
  logic [15:0] row_base;
  logic [7:0]  lead_first;
  logic [5:0]  row;
  logic [7:0]  col;
  logic [15:0] serial;
  logic [15:0] store_base;
  logic [2:0]  font;
  logic [15:0] diff;
  glyph_item_t big5_glyph;
  glyph_item_t lead_ascii;
  glyph_item_t byte_ascii;

  assign hi = lead_value;
  assign lo = item.text_byte;

  always_comb begin
    supp_pair = (hi == 8'hc6) && (lo >= 8'ha1) && (lo <= 8'hfe);

    lead_ok    = 1'b1;
    row_base   = BASE_SPECIAL;
    lead_first = 8'ha1;
    priority if (hi >= 8'ha1 && hi <= 8'ha3) begin
      row_base = BASE_SPECIAL;  lead_first = 8'ha1;
    end else if (hi >= 8'ha4 && hi <= 8'hc6) begin
      row_base = BASE_STANDARD; lead_first = 8'ha4;
    end else if (hi >= 8'hc7 && hi <= 8'hc8) begin
      row_base = BASE_EXTRA;    lead_first = 8'hc7;
    end else if (hi >= 8'hc9 && hi <= 8'hf9) begin
      row_base = BASE_HIGH;     lead_first = 8'hc9;
    end else begin
      lead_ok = 1'b0;
    end
    row = 6'(hi - lead_first);

    trail_ok = 1'b1;
    priority if (lo >= 8'h40 && lo <= 8'h7e) begin
      col = lo - 8'h40;
    end else if (lo >= 8'ha1 && lo <= 8'hfe) begin
      col = lo - 8'ha1 + TRAIL_SKIP;
    end else begin
      col      = 8'd0;
      trail_ok = 1'b0;
    end

    if (supp_pair) begin
      serial = BASE_SUPPLEM + 16'(lo - 8'ha1);
    end else begin
      serial = row_base + 16'(row) * SERIAL_ROW + 16'(col);
    end
    pair_ok = lead_held && (supp_pair || (lead_ok && trail_ok));

    // Each font store covers its own serial window.
    priority if (serial >= BASE_SUPPLEM && serial <= LAST_SUPPLEM) begin
      font = FONT_SUPPLEM;  store_base = BASE_SUPPLEM;
    end else if (serial >= BASE_SPECIAL && serial <= LAST_SPECIAL) begin
      font = FONT_SPECIAL;  store_base = BASE_SPECIAL;
    end else if (serial >= BASE_STANDARD && serial <= LAST_STANDARD) begin
      font = FONT_STANDARD; store_base = BASE_STANDARD;
    end else begin
      font = FONT_NONE;     store_base = serial;
    end
    diff = serial - store_base;

    big5_glyph.glyph_kind    = GLYPH_BIG5;
    big5_glyph.serial_number = serial;
    big5_glyph.font_select   = font;
    big5_glyph.byte_offset   = 19'(diff) * GLYPH_BYTES;
    big5_glyph.glyph_code    = hi;
    big5_glyph.final_glyph   = item.end_of_text;

    lead_ascii.glyph_kind    = GLYPH_ASCII;
    lead_ascii.serial_number = 16'd0;
    lead_ascii.font_select   = FONT_ASCII;
    lead_ascii.byte_offset   = 19'(hi) * ASCII_BYTES;
    lead_ascii.glyph_code    = hi;
    lead_ascii.final_glyph   = 1'b0;

    byte_ascii.glyph_kind    = GLYPH_ASCII;
    byte_ascii.serial_number = 16'd0;
    byte_ascii.font_select   = FONT_ASCII;
    byte_ascii.byte_offset   = 19'(lo) * ASCII_BYTES;
    byte_ascii.glyph_code    = lo;
    byte_ascii.final_glyph   = 1'b1;

    result.second = byte_ascii;
    if (pair_ok) begin
      result.count     = 2'd1;
      result.first     = big5_glyph;
      result.held_next = 1'b0;
    end else begin
      // A failed pair flushes the held byte; a final byte goes out at once.
      result.count     = 2'({1'b0, lead_held}) + 2'({1'b0, item.end_of_text});
      result.first     = lead_held ? lead_ascii : byte_ascii;
      result.held_next = ~item.end_of_text;
    end
  end

endmodule

// ----- rtl/big5_stream_to_font_address.sv -----
// Top level: Big5/ASCII byte stream to ETen font glyph address items.
//
// Channel  Direction  Handshake                  Payload
// text     in         text_valid / text_ready    text_item  (text_byte, end_of_text)
// glyph    out        glyph_valid / glyph_ready  glyph_item (kind, serial, font, offset,
//                                                            code, final)
//
// Each accepted text item is first captured in an input register. The decoder
// then pairs it with the held lead byte and, once the item retires, writes zero,
// one or two glyph items into a two-entry output queue whose head is the output;
// a glyph passes the input register, then the queue. One text item is taken
// per cycle as long as the queue, after this cycle's pop, has room for all the
// glyphs of the item in the input register. A full queue that is not popped
// stalls any item that makes a glyph, and a failed pair that must emit two
// glyphs waits until the queue drains to empty. Synchronous reset empties both
// stages and drops any held lead byte.
module big5_stream_to_font_address (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     text_valid,
  output logic                     text_ready,
  input  b5fa_pkg::text_item_t     text_item,
  output logic                     glyph_valid,
  input  logic                     glyph_ready,
  output b5fa_pkg::glyph_item_t    glyph_item
);
  import b5fa_pkg::*;

  // Input register holding the item waiting to be decoded.
  text_item_t  stage_item;
  logic        stage_valid;

  // Lead byte state that carries across items.
  logic        lead_held;
  logic [7:0]  lead_value;

  // Two-entry output queue; entry 0 is the head shown on the output.
  glyph_item_t queue [2];
  glyph_item_t queue_next [2];
  logic [1:0]  queue_count;
  logic [1:0]  count_after_pop;
  logic [1:0]  queue_count_next;

  decode_t     dec;
  logic        pop;
  logic        retire;
  logic        accept;

  b5fa_decode u_decode (
    .lead_held  (lead_held),
    .lead_value (lead_value),
    .item       (stage_item),
    .result     (dec)
  );

  assign glyph_valid = (queue_count != 2'd0);
  assign glyph_item  = queue[0];
  assign pop         = glyph_valid && glyph_ready;

  // The staged item retires only when all of its glyphs fit in the queue.
  assign count_after_pop = queue_count - 2'({1'b0, pop});
  assign retire = stage_valid && ((2'd2 - count_after_pop) >= dec.count);
  assign text_ready = !stage_valid || retire;
  assign accept     = text_valid && text_ready;

  assign queue_count_next = retire ? count_after_pop + dec.count : count_after_pop;

  // The queue shifts on a pop, then new glyphs land behind what is left.
  always_comb begin
    queue_next[0] = pop ? queue[1] : queue[0];
    queue_next[1] = queue[1];
    if (retire && dec.count != 2'd0) begin
      queue_next[count_after_pop[0]] = dec.first;
    end
    if (retire && dec.count == 2'd2) begin
      queue_next[1] = dec.second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
      lead_held   <= 1'b0;
      lead_value  <= 8'd0;
      queue_count <= 2'd0;
    end else begin
      if (accept) begin
        stage_valid <= 1'b1;
      end else if (retire) begin
        stage_valid <= 1'b0;
      end
      if (retire) begin
        lead_held  <= dec.held_next;
        lead_value <= dec.held_next ? stage_item.text_byte : 8'd0;
      end
      queue_count <= queue_count_next;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      stage_item <= text_item;
    end
    queue[0] <= queue_next[0];
    queue[1] <= queue_next[1];
  end

endmodule
